// ===== hdl/sgi_pkg.sv =====
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared widths, codes and types of the support Gini impurity unit.
// ----------------------------------------------------------------------------
package sgi_pkg;

  localparam int unsigned DIM_W           = 3;
  localparam int unsigned LEVEL_W         = 4;
  localparam int unsigned INDEX_W         = 16;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned COORD_W         = COORD_FRAC_BITS + 1;
  localparam int unsigned COUNT_BITS      = 20;
  localparam int unsigned PROD_W          = 2 * COUNT_BITS;
  localparam int unsigned IMP_W           = 16;
  localparam int unsigned FRAC_STEPS      = IMP_W + 1;
  localparam int unsigned STEP_CNT_W      = $clog2(FRAC_STEPS + 1);
  localparam int unsigned CFG_W           = 4;
  localparam int unsigned EFF_W           = CFG_W + 1;

  // shifted coordinate and bounds share one compare width
  localparam int unsigned BOUND_W = INDEX_W + 1 + COORD_FRAC_BITS;

  localparam logic [CFG_W-1:0] NUM_DIMS_RST = CFG_W'(2);

  // item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [FRAC_STEPS-1:0] frac_t;

endpackage

// ===== hdl/sgi_if.sv =====
// ----------------------------------------------------------------------------
// sgi_if
// Handshake channels of the support Gini impurity unit: input and result.
// ----------------------------------------------------------------------------
interface sgi_in_if
  import sgi_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [DIM_W-1:0]     dim;
  logic [LEVEL_W-1:0]   grid_level;
  logic [INDEX_W-1:0]   grid_index;
  logic [COORD_W-1:0]   coordinate;
  logic                 class_is_one;
  logic                 last_row;

  modport source (
    output valid, func, dim, grid_level, grid_index, coordinate, class_is_one, last_row,
    input  ready
  );
  modport sink (
    input  valid, func, dim, grid_level, grid_index, coordinate, class_is_one, last_row,
    output ready
  );
endinterface

interface sgi_out_if
  import sgi_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [IMP_W-1:0]      impurity;
  logic [COUNT_BITS-1:0] support_count;
  logic [COUNT_BITS-1:0] class_one_count;

  modport source (
    output valid, impurity, support_count, class_one_count,
    input  ready
  );
  modport sink (
    input  valid, impurity, support_count, class_one_count,
    output ready
  );
endinterface

// ===== hdl/sgi_frac_div.sv =====
// ----------------------------------------------------------------------------
// sgi_frac_div
// Restoring fraction divider: floor(2^17 * p / q), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sgi_frac_div
  import sgi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  prod_t p_i,
  input  prod_t q_i,
  output logic  done_o,
  output frac_t quot_o
);

  prod_t                 rem_q, rem_d;
  prod_t                 den_q;
  frac_t                 quot_q, quot_d;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [PROD_W:0]       rem2;
  logic                  take;

  // remainder stays below the divisor, so twice it fits one extra bit
  assign rem2 = {rem_q, 1'b0};
  assign take = rem2 >= {1'b0, den_q};

  always_comb begin
    rem_d  = take ? PROD_W'(rem2 - {1'b0, den_q}) : rem2[PROD_W-1:0];
    quot_d = {quot_q[FRAC_STEPS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_CNT_W'(FRAC_STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_CNT_W'(1);
      if (cnt_q == STEP_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= p_i;
      den_q  <= q_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hdl/support_gini_impurity_unit.sv =====
// ----------------------------------------------------------------------------
// support_gini_impurity_unit
// Counts data rows inside the support of one sparse-grid point and reports
// the two-class Gini impurity of those rows after the last row.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  cfg       in   cfg_we_i      cfg_data_i (num_dims)
//  in_i      in   valid/ready   func, dim, grid_level, grid_index, coordinate,
//                               class_is_one, last_row
//  out_o     out  valid/ready   impurity, support_count, class_one_count
//
//  Grid loads and row coordinates complete in their accept cycle: shift and
//  bound compare sit in that cycle. The final coordinate of a row marked
//  last_row starts the result sequence: two passes of the shared 20x20
//  multiplier, then the restoring divider, then a load of the output
//  register, with in_i.ready low throughout. A stalled result holds in
//  the output register; a second result waits in the divider until it drains.
//  Reset clears control and counters; the grid point store is not cleared.
// ----------------------------------------------------------------------------
module support_gini_impurity_unit
  import sgi_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  sgi_in_if.sink           in_i,
  sgi_out_if.source        out_o
);

  localparam int unsigned IdxW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_AB = 3'd1;
  localparam logic [2:0] ST_MUL_NN = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;

  logic [2:0]         state_q, state_d;
  logic [CFG_W-1:0]   num_dims_q;
  logic [LEVEL_W-1:0] lvl_mem [MAX_DIMS];
  logic [INDEX_W-1:0] idx_mem [MAX_DIMS];
  logic               row_inside_q;
  count_t             total_q, ones_q;
  count_t             n_op_q, a_op_q;
  logic               n_zero_q;
  prod_t              p_q;

  logic               out_valid_q;
  logic [IMP_W-1:0]   imp_q;
  count_t             sup_q, one_q;

  logic [EFF_W-1:0]   eff_dims;
  logic [EFF_W-1:0]   dim_ext;
  logic [IdxW-1:0]    rd_idx;
  logic [LEVEL_W-1:0] lvl;
  logic [INDEX_W-1:0] idx;
  logic [BOUND_W-1:0] scaled, lo_bound, hi_bound;
  logic               in_sup;
  logic               acc, load_acc, data_acc, row_end, row_ok;
  count_t             total_nx, ones_nx;
  count_t             mul_x, mul_y;
  prod_t              mul_p;
  logic               div_start, div_done;
  frac_t              div_quot;
  logic               out_free, out_load;

  // clamp num_dims to 1..MAX_DIMS
  always_comb begin
    if (num_dims_q == '0) begin
      eff_dims = EFF_W'(1);
    end else if (32'(num_dims_q) > 32'(MAX_DIMS)) begin
      eff_dims = EFF_W'(MAX_DIMS);
    end else begin
      eff_dims = EFF_W'(num_dims_q);
    end
  end

  assign dim_ext  = EFF_W'(in_i.dim);
  assign rd_idx   = IdxW'(in_i.dim);
  assign acc      = in_i.valid && in_i.ready;
  assign load_acc = acc && (in_i.func == FUNC_LOAD) && (32'(in_i.dim) < 32'(MAX_DIMS));
  assign data_acc = acc && (in_i.func == FUNC_DATA) && (dim_ext < eff_dims);
  assign row_end  = data_acc && (dim_ext == eff_dims - EFF_W'(1));

  // support test: v * 2^level against (index -/+ 1) * 2^F
  always_comb begin
    lvl      = lvl_mem[rd_idx];
    idx      = idx_mem[rd_idx];
    scaled   = BOUND_W'(in_i.coordinate) << lvl;
    hi_bound = {(INDEX_W + 1)'(idx) + (INDEX_W + 1)'(1), COORD_FRAC_BITS'(0)};
    lo_bound = {(INDEX_W + 1)'(idx) - (INDEX_W + 1)'(1), COORD_FRAC_BITS'(0)};
    in_sup   = ((idx == '0) || (scaled >= lo_bound)) && (scaled <= hi_bound);
    row_ok   = row_inside_q && in_sup;
  end

  // saturating counts including the row that ends now
  always_comb begin
    total_nx = total_q;
    ones_nx  = ones_q;
    if (row_ok) begin
      if (total_q != '1) begin
        total_nx = total_q + COUNT_BITS'(1);
      end
      if (in_i.class_is_one && (ones_q != '1)) begin
        ones_nx = ones_q + COUNT_BITS'(1);
      end
    end
  end

  // shared multiplier: a*b first, then n*n
  always_comb begin
    if (state_q == ST_MUL_AB) begin
      mul_x = a_op_q;
      mul_y = n_op_q - a_op_q;
    end else begin
      mul_x = n_op_q;
      mul_y = n_op_q;
    end
    mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);
  end

  assign out_free  = !out_valid_q || out_o.ready;
  assign div_start = (state_q == ST_MUL_NN);
  assign out_load  = (state_q == ST_DIV) && div_done && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (row_end && in_i.last_row) begin
          state_d = ST_MUL_AB;
        end
      end
      ST_MUL_AB: state_d = ST_MUL_NN;
      ST_MUL_NN: state_d = ST_DIV;
      ST_DIV: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_dims_q   <= NUM_DIMS_RST;
      row_inside_q <= 1'b1;
      total_q      <= '0;
      ones_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_dims_q <= cfg_data_i;
      end
      if (data_acc) begin
        row_inside_q <= row_end ? 1'b1 : row_ok;
      end
      if (row_end) begin
        // clear the counters once the final row hands them to the sequencer
        total_q <= in_i.last_row ? '0 : total_nx;
        ones_q  <= in_i.last_row ? '0 : ones_nx;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      lvl_mem[rd_idx] <= in_i.grid_level;
      idx_mem[rd_idx] <= in_i.grid_index;
    end
    if (row_end && in_i.last_row) begin
      n_op_q   <= total_nx;
      a_op_q   <= ones_nx;
      n_zero_q <= (total_nx == '0);
    end
    if (state_q == ST_MUL_AB) begin
      p_q <= mul_p;
    end
    if (out_load) begin
      imp_q <= n_zero_q ? '0 : div_quot[IMP_W-1:0];
      sup_q <= n_op_q;
      one_q <= a_op_q;
    end
  end

  sgi_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_q),
    .q_i     (mul_p),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.impurity        = imp_q;
  assign out_o.support_count   = sup_q;
  assign out_o.class_one_count = one_q;

endmodule
